// ===== rtl/dlt_pkg.sv =====
package dlt_pkg;

    localparam int unsigned READING_W = 10;
    localparam int unsigned ANGLE_W   = 8;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [ANGLE_W-1:0]   ANGLE_MAX    = 8'd180;
    localparam logic [ANGLE_W-1:0]   STEP_DEG     = 8'd2;
    localparam logic [READING_W-1:0] KNOB_MAX     = 10'd1023;
    localparam logic [ANGLE_W-1:0]   H_POS_RESET  = 8'd40;
    localparam logic [ANGLE_W-1:0]   V_POS_RESET  = 8'd90;
    localparam logic [READING_W-1:0] THR_RESET    = 10'd30;
    localparam logic [READING_W-1:0] MAN_THR_RESET = 10'd60;

    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_H_THRESH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_V_THRESH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAN_THRESH = 2'd3;

    typedef enum logic [1:0] {
        STEP_NONE = 2'd0,
        STEP_UP   = 2'd1,
        STEP_DOWN = 2'd2
    } t_step;

    typedef struct packed {
        logic                 auto_mode;
        t_step                h_step;
        t_step                v_step;
        logic [READING_W-1:0] knob;
        logic                 axis;
        logic [ANGLE_W-1:0]   target;
    } t_cmd;

endpackage

// ===== rtl/dlt_front.sv =====
module dlt_front
    import dlt_pkg::*;
(
    input  logic [READING_W-1:0] i_top_right,
    input  logic [READING_W-1:0] i_top_left,
    input  logic [READING_W-1:0] i_bottom_right,
    input  logic [READING_W-1:0] i_bottom_left,
    input  logic [READING_W-1:0] i_knob_value,
    input  logic                 i_axis_choice,
    input  logic                 i_auto_mode,
    input  logic [READING_W-1:0] i_h_thresh,
    input  logic [READING_W-1:0] i_v_thresh,
    output t_cmd                 o_cmd
);

    logic [READING_W:0]   w_sum_top;
    logic [READING_W:0]   w_sum_bot;
    logic [READING_W:0]   w_sum_left;
    logic [READING_W:0]   w_sum_right;
    logic [READING_W:0]   w_vdiff;
    logic [READING_W:0]   w_hdiff;
    logic [READING_W-1:0] w_vmag;
    logic [READING_W-1:0] w_hmag;
    logic [17:0]          w_prod;
    logic [ANGLE_W-1:0]   w_q0;
    logic [READING_W:0]   w_rem;
    t_step                w_h_step;
    t_step                w_v_step;

    // pair averages, halved sums
    always_comb begin
        w_sum_top   = {1'b0, i_top_right} + {1'b0, i_top_left};
        w_sum_bot   = {1'b0, i_bottom_right} + {1'b0, i_bottom_left};
        w_sum_left  = {1'b0, i_top_left} + {1'b0, i_bottom_left};
        w_sum_right = {1'b0, i_top_right} + {1'b0, i_bottom_right};
        w_vdiff = {1'b0, w_sum_top[READING_W:1]} - {1'b0, w_sum_bot[READING_W:1]};
        w_hdiff = {1'b0, w_sum_right[READING_W:1]} - {1'b0, w_sum_left[READING_W:1]};
        w_vmag  = w_vdiff[READING_W] ? READING_W'(-w_vdiff) : w_vdiff[READING_W-1:0];
        w_hmag  = w_hdiff[READING_W] ? READING_W'(-w_hdiff) : w_hdiff[READING_W-1:0];
    end

    always_comb begin
        w_v_step = STEP_NONE;
        if ((w_vmag >= i_v_thresh) && (w_vdiff != '0)) begin
            w_v_step = w_vdiff[READING_W] ? STEP_DOWN : STEP_UP;
        end
        w_h_step = STEP_NONE;
        if ((w_hmag >= i_h_thresh) && (w_hdiff != '0)) begin
            w_h_step = w_hdiff[READING_W] ? STEP_DOWN : STEP_UP;
        end
    end

    // knob * 180 / 1023: divide by 1024, then one correction step
    always_comb begin
        w_prod = 18'(i_knob_value) * 18'(ANGLE_MAX);
        w_q0   = w_prod[17:10];
        w_rem  = {1'b0, w_prod[9:0]} + (READING_W+1)'(w_q0);
    end

    always_comb begin
        o_cmd.auto_mode = i_auto_mode;
        o_cmd.h_step    = w_h_step;
        o_cmd.v_step    = w_v_step;
        o_cmd.knob      = i_knob_value;
        o_cmd.axis      = i_axis_choice;
        o_cmd.target    = (w_rem >= {1'b0, KNOB_MAX}) ? w_q0 + 8'd1 : w_q0;
    end

endmodule

// ===== rtl/dlt_queue.sv =====
module dlt_queue
    import dlt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_count;
    logic       w_push;
    logic       w_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = w_push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = w_pop ? !r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 2'd1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("queue count out of range");

    a_ptrs_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_count == 2'd0) || (r_count == 2'd2)) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");

    a_pop_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_push) |=> (r_count == $past(r_count) - 2'd1))
        else $error("pop did not free an entry");
`endif

endmodule

// ===== rtl/dlt_back.sv =====
module dlt_back
    import dlt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  t_cmd                 i_cmd,
    output logic                 o_pop,
    input  logic [READING_W-1:0] i_man_thresh,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [ANGLE_W-1:0]   o_h_angle,
    output logic [ANGLE_W-1:0]   o_v_angle
);

    logic [ANGLE_W-1:0]   r_h_pos;
    logic [ANGLE_W-1:0]   r_v_pos;
    logic [READING_W-1:0] r_h_knob;
    logic [READING_W-1:0] r_v_knob;
    logic                 r_out_valid;
    logic [ANGLE_W-1:0]   n_h_pos;
    logic [ANGLE_W-1:0]   n_v_pos;
    logic [READING_W-1:0] n_h_knob;
    logic [READING_W-1:0] n_v_knob;
    logic [READING_W-1:0] w_last;
    logic [READING_W:0]   w_kdiff;
    logic [READING_W-1:0] w_kmag;
    logic                 w_apply;

    function automatic logic [ANGLE_W-1:0] step_pos(input logic [ANGLE_W-1:0] pos,
                                                    input t_step dir);
        logic [ANGLE_W-1:0] res;
        res = pos;
        case (dir)
            STEP_UP: begin
                if (pos < ANGLE_MAX) begin
                    res = (pos > ANGLE_MAX - STEP_DEG) ? ANGLE_MAX : pos + STEP_DEG;
                end
            end
            STEP_DOWN: begin
                if (pos != '0) begin
                    res = (pos < STEP_DEG) ? '0 : pos - STEP_DEG;
                end
            end
            default: res = pos;
        endcase
        return res;
    endfunction

    assign o_pop     = i_valid && (!r_out_valid || i_ready);
    assign o_valid   = r_out_valid;
    assign o_h_angle = r_h_pos;
    assign o_v_angle = r_v_pos;

    always_comb begin
        w_last  = i_cmd.axis ? r_v_knob : r_h_knob;
        w_kdiff = {1'b0, i_cmd.knob} - {1'b0, w_last};
        w_kmag  = w_kdiff[READING_W] ? READING_W'(-w_kdiff) : w_kdiff[READING_W-1:0];
        w_apply = (w_kmag > i_man_thresh);
    end

    always_comb begin
        n_h_pos  = r_h_pos;
        n_v_pos  = r_v_pos;
        n_h_knob = r_h_knob;
        n_v_knob = r_v_knob;
        if (i_cmd.auto_mode) begin
            n_h_pos = step_pos(r_h_pos, i_cmd.h_step);
            n_v_pos = step_pos(r_v_pos, i_cmd.v_step);
        end else if (w_apply) begin
            if (i_cmd.axis) begin
                n_v_pos  = i_cmd.target;
                n_v_knob = i_cmd.knob;
            end else begin
                n_h_pos  = i_cmd.target;
                n_h_knob = i_cmd.knob;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_pos     <= H_POS_RESET;
            r_v_pos     <= V_POS_RESET;
            r_h_knob    <= '0;
            r_v_knob    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_h_pos  <= n_h_pos;
                r_v_pos  <= n_v_pos;
                r_h_knob <= n_h_knob;
                r_v_knob <= n_v_knob;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_h_pos <= ANGLE_MAX) && (r_v_pos <= ANGLE_MAX))
        else $error("angle beyond limit");

    a_state_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> ($stable(r_h_pos) && $stable(r_v_pos)))
        else $error("state changed while result pending");

    a_pop_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_out_valid)
        else $error("popped command produced no result");
`endif

endmodule

// ===== rtl/dual_axis_light_tracker.sv =====
// channel   dir  tvalid/tready          tdata (low bit up)                 tuser
// s         in   i_s_tvalid/o_s_tready  top_right, top_left, bottom_right, axis_choice
//                                       bottom_left, knob_value, pad 6
// m         out  o_m_tvalid/i_m_tready  horizontal_angle, vertical_angle   -
// cfg       in   i_cfg_we               i_cfg_index, i_cfg_data            -
//
// one transaction per cycle sustained while i_m_tready stays high; a result passes
// through the command queue and then the angle state registers
// two-entry command queue lets input continue while a result waits on i_m_tready
// i_rst_n is synchronous: angles 40 and 90, last knobs 0, thresholds 30, 30, 60
module dual_axis_light_tracker
    import dlt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // top_right, top_left, bottom_right, bottom_left, knob_value, zero pad
    input  logic [55:0]          i_s_tdata,
    // axis_choice
    input  logic                 i_s_tuser,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // horizontal_angle, vertical_angle
    output logic [15:0]          o_m_tdata,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [READING_W-1:0] i_cfg_data
);

    logic                 r_auto_mode;
    logic [READING_W-1:0] r_h_thresh;
    logic [READING_W-1:0] r_v_thresh;
    logic [READING_W-1:0] r_man_thresh;
    t_cmd                 w_front_cmd;
    t_cmd                 w_back_cmd;
    logic                 w_full;
    logic                 w_q_valid;
    logic                 w_pop;
    logic [ANGLE_W-1:0]   w_h_angle;
    logic [ANGLE_W-1:0]   w_v_angle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto_mode  <= 1'b0;
            r_h_thresh   <= THR_RESET;
            r_v_thresh   <= THR_RESET;
            r_man_thresh <= MAN_THR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_AUTO_MODE:  r_auto_mode  <= i_cfg_data[0];
                CFG_H_THRESH:   r_h_thresh   <= i_cfg_data;
                CFG_V_THRESH:   r_v_thresh   <= i_cfg_data;
                CFG_MAN_THRESH: r_man_thresh <= i_cfg_data;
                default: ;
            endcase
        end
    end

    dlt_front u_front (
        .i_top_right    (i_s_tdata[9:0]),
        .i_top_left     (i_s_tdata[19:10]),
        .i_bottom_right (i_s_tdata[29:20]),
        .i_bottom_left  (i_s_tdata[39:30]),
        .i_knob_value   (i_s_tdata[49:40]),
        .i_axis_choice  (i_s_tuser),
        .i_auto_mode    (r_auto_mode),
        .i_h_thresh     (r_h_thresh),
        .i_v_thresh     (r_v_thresh),
        .o_cmd          (w_front_cmd)
    );

    dlt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_s_tvalid),
        .i_cmd   (w_front_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_back_cmd)
    );

    dlt_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_q_valid),
        .i_cmd        (w_back_cmd),
        .o_pop        (w_pop),
        .i_man_thresh (r_man_thresh),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_h_angle    (w_h_angle),
        .o_v_angle    (w_v_angle)
    );

    assign o_s_tready = !w_full;
    assign o_m_tdata  = {w_v_angle, w_h_angle};

endmodule

// ===== verif/tb_dual_axis_light_tracker.sv =====
module tb_dual_axis_light_tracker;
    import dlt_pkg::*;

    localparam int QUIET_CYCLES = 4;
    localparam int N_RANDOM     = 700;

    typedef enum logic [1:0] {
        SEND_READINGS,
        WRITE_REG,
        WAIT_IDLE
    } t_job_kind;

    typedef struct {
        t_job_kind            kind;
        logic [55:0]          data;
        logic                 axis;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [READING_W-1:0] value;
        int                   gap;
    } t_job;

    typedef struct {
        logic [ANGLE_W-1:0] h;
        logic [ANGLE_W-1:0] v;
    } t_angle_pair;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [55:0]          i_s_tdata   = '0;
    logic                 i_s_tuser   = 1'b0;
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic [15:0]          o_m_tdata;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [READING_W-1:0] i_cfg_data  = '0;

    dual_axis_light_tracker DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    t_job        pending_jobs[$];
    t_angle_pair expected_angles[$];
    int          err_cnt = 0;

    // tracker state as predicted
    logic                 trk_auto;
    logic [READING_W-1:0] trk_h_thr;
    logic [READING_W-1:0] trk_v_thr;
    logic [READING_W-1:0] trk_man_thr;
    logic [ANGLE_W-1:0]   trk_h_pos;
    logic [ANGLE_W-1:0]   trk_v_pos;
    logic [READING_W-1:0] trk_h_knob;
    logic [READING_W-1:0] trk_v_knob;

    // driver state
    t_job cur_job;
    logic have_job = 1'b0;
    int   gap_cnt;
    int   quiet_cnt;
    logic nxt_valid;
    logic nxt_we;

    // receiver state
    int   stall_cnt = 0;
    int   rx_count  = 0;
    logic rx_steady = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic [READING_W-1:0] pick_reading();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return KNOB_MAX;
        return READING_W'($urandom_range(0, 1023));
    endfunction

    function automatic logic [READING_W-1:0] near_reading(input int base);
        int v;
        v = base + $urandom_range(0, 128) - 64;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        return READING_W'(v);
    endfunction

    function automatic logic [READING_W-1:0] pick_thr();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return '0;
        if (r == 1) return KNOB_MAX;
        if (r == 2) return READING_W'($urandom_range(0, 1023));
        return READING_W'($urandom_range(0, 80));
    endfunction

    function automatic void add_item(input int tr, input int tl, input int br, input int bl,
                                     input int knob, input int axis, input int gap);
        t_job j;
        j.kind    = SEND_READINGS;
        j.data    = {6'd0, 10'(knob), 10'(bl), 10'(br), 10'(tl), 10'(tr)};
        j.axis    = axis[0];
        j.reg_idx = '0;
        j.value   = '0;
        j.gap     = gap;
        pending_jobs.push_back(j);
    endfunction

    function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [READING_W-1:0] val);
        t_job j;
        j.kind    = WRITE_REG;
        j.data    = '0;
        j.axis    = 1'b0;
        j.reg_idx = idx;
        j.value   = val;
        j.gap     = 0;
        pending_jobs.push_back(j);
    endfunction

    function automatic void add_wait();
        t_job j;
        j.kind    = WAIT_IDLE;
        j.data    = '0;
        j.axis    = 1'b0;
        j.reg_idx = '0;
        j.value   = '0;
        j.gap     = 0;
        pending_jobs.push_back(j);
    endfunction

    function automatic void reset_tracker();
        trk_auto    = 1'b0;
        trk_h_thr   = THR_RESET;
        trk_v_thr   = THR_RESET;
        trk_man_thr = MAN_THR_RESET;
        trk_h_pos   = H_POS_RESET;
        trk_v_pos   = V_POS_RESET;
        trk_h_knob  = '0;
        trk_v_knob  = '0;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [READING_W-1:0] val);
        case (idx)
            CFG_AUTO_MODE:  trk_auto    = val[0];
            CFG_H_THRESH:   trk_h_thr   = val;
            CFG_V_THRESH:   trk_v_thr   = val;
            CFG_MAN_THRESH: trk_man_thr = val;
            default: ;
        endcase
    endfunction

    function automatic logic [ANGLE_W-1:0] step_angle(input logic [ANGLE_W-1:0] pos,
                                                      input int diff,
                                                      input logic [READING_W-1:0] thr);
        int mag;
        int p;
        mag = (diff < 0) ? -diff : diff;
        p   = int'(pos);
        if (mag >= int'(thr)) begin
            if (diff > 0 && p < int'(ANGLE_MAX))
                p = (p + int'(STEP_DEG) > int'(ANGLE_MAX)) ? int'(ANGLE_MAX) : p + int'(STEP_DEG);
            else if (diff < 0 && p > 0)
                p = (p < int'(STEP_DEG)) ? 0 : p - int'(STEP_DEG);
        end
        return ANGLE_W'(p);
    endfunction

    function automatic void predict_angles(input logic [55:0] d, input logic axis);
        int tr, tl, br, bl, knob;
        int top_avg, bot_avg, left_avg, right_avg, target, delta;
        t_angle_pair e;
        tr   = int'(d[9:0]);
        tl   = int'(d[19:10]);
        br   = int'(d[29:20]);
        bl   = int'(d[39:30]);
        knob = int'(d[49:40]);
        if (trk_auto) begin
            top_avg   = (tr + tl) / 2;
            bot_avg   = (br + bl) / 2;
            left_avg  = (tl + bl) / 2;
            right_avg = (tr + br) / 2;
            trk_h_pos = step_angle(trk_h_pos, right_avg - left_avg, trk_h_thr);
            trk_v_pos = step_angle(trk_v_pos, top_avg - bot_avg, trk_v_thr);
        end else begin
            target = knob * int'(ANGLE_MAX) / int'(KNOB_MAX);
            if (!axis) begin
                delta = knob - int'(trk_h_knob);
                if (delta < 0) delta = -delta;
                if (delta > int'(trk_man_thr)) begin
                    trk_h_pos  = ANGLE_W'(target);
                    trk_h_knob = READING_W'(knob);
                end
            end else begin
                delta = knob - int'(trk_v_knob);
                if (delta < 0) delta = -delta;
                if (delta > int'(trk_man_thr)) begin
                    trk_v_pos  = ANGLE_W'(target);
                    trk_v_knob = READING_W'(knob);
                end
            end
        end
        e.h = trk_h_pos;
        e.v = trk_v_pos;
        expected_angles.push_back(e);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_tracker();
            have_job = 1'b0;
            i_s_tvalid <= 1'b0;
            i_cfg_we   <= 1'b0;
        end else begin
            nxt_valid = i_s_tvalid;
            nxt_we    = 1'b0;
            if (i_s_tvalid && o_s_tready) begin
                predict_angles(i_s_tdata, i_s_tuser);
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (!have_job && pending_jobs.size() > 0) begin
                    cur_job   = pending_jobs.pop_front();
                    have_job  = 1'b1;
                    gap_cnt   = cur_job.gap;
                    quiet_cnt = QUIET_CYCLES;
                end
                if (have_job) begin
                    if (gap_cnt > 0) begin
                        gap_cnt--;
                    end else begin
                        case (cur_job.kind)
                            SEND_READINGS: begin
                                nxt_valid = 1'b1;
                                i_s_tdata <= cur_job.data;
                                i_s_tuser <= cur_job.axis;
                                have_job  = 1'b0;
                            end
                            WRITE_REG: begin
                                nxt_we = 1'b1;
                                i_cfg_index <= cur_job.reg_idx;
                                i_cfg_data  <= cur_job.value;
                                apply_reg(cur_job.reg_idx, cur_job.value);
                                have_job = 1'b0;
                            end
                            default: begin
                                if (expected_angles.size() == 0) begin
                                    if (quiet_cnt > 0) quiet_cnt--;
                                    else have_job = 1'b0;
                                end
                            end
                        endcase
                    end
                end
            end
            i_s_tvalid <= nxt_valid;
            i_cfg_we   <= nxt_we;
        end
    end

    always @(posedge i_clk) begin
        t_angle_pair e;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            stall_cnt = 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_angles.size() == 0) begin
                    err_cnt++;
                    $error("unexpected transaction: horizontal_angle %0d vertical_angle %0d",
                           o_m_tdata[7:0], o_m_tdata[15:8]);
                end else begin
                    e = expected_angles.pop_front();
                    if (o_m_tdata[7:0] !== e.h) begin
                        err_cnt++;
                        $error("horizontal_angle: expected %0d, actual %0d",
                               e.h, o_m_tdata[7:0]);
                    end
                    if (o_m_tdata[15:8] !== e.v) begin
                        err_cnt++;
                        $error("vertical_angle: expected %0d, actual %0d",
                               e.v, o_m_tdata[15:8]);
                    end
                end
                rx_count++;
                if (rx_count % 50 == 0) rx_steady = ($urandom_range(0, 3) == 0);
                stall_cnt = rx_steady ? 0 : pick_gap();
            end
            if (stall_cnt > 0) begin
                i_m_tready <= 1'b0;
                stall_cnt--;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    initial begin : stim
        int n_sent;
        int len;
        int base;
        int gap;
        int k;
        logic calm;
        logic near;

        // manual mode, default thresholds
        add_item(0, 1023, 0, 1023, 1023, 0, 0);
        add_item(1023, 0, 1023, 0, 1000, 0, pick_gap());
        add_item(512, 512, 512, 512, 0, 1, pick_gap());
        add_item(0, 0, 0, 0, 300, 0, 0);
        add_item(1023, 1023, 1023, 1023, 1018, 0, pick_gap());
        add_item(0, 1023, 1023, 0, 1023, 1, 0);
        add_wait();
        add_reg(CFG_MAN_THRESH, '0);
        add_item(0, 0, 0, 0, 6, 1, 0);
        add_item(0, 0, 0, 0, 6, 1, pick_gap());
        // auto mode with zero thresholds: zero difference and angle limits
        add_wait();
        add_reg(CFG_AUTO_MODE, READING_W'(1));
        add_reg(CFG_H_THRESH, '0);
        add_reg(CFG_V_THRESH, '0);
        add_item(512, 512, 512, 512, 1023, 1, 0);
        add_item(1023, 0, 1023, 0, 0, 0, 0);
        add_item(1023, 0, 1023, 0, 512, 1, pick_gap());
        add_item(0, 0, 1023, 1023, 0, 0, 0);
        add_item(0, 0, 1023, 1023, 1023, 1, 0);
        // highest thresholds
        add_wait();
        add_reg(CFG_H_THRESH, KNOB_MAX);
        add_reg(CFG_V_THRESH, KNOB_MAX);
        add_item(0, 1023, 0, 1023, 0, 0, 0);
        add_item(1023, 1023, 0, 0, 0, 1, pick_gap());
        add_item(1023, 0, 0, 0, 1023, 0, 0);
        add_wait();
        add_reg(CFG_AUTO_MODE, READING_W'(0));
        add_reg(CFG_MAN_THRESH, KNOB_MAX);
        add_item(1023, 1023, 1023, 1023, 0, 0, 0);
        add_item(0, 0, 0, 0, 1023, 1, 0);

        n_sent = 0;
        while (n_sent < N_RANDOM) begin
            add_wait();
            add_reg(CFG_AUTO_MODE, READING_W'($urandom_range(0, 1)));
            add_reg(CFG_H_THRESH, pick_thr());
            add_reg(CFG_V_THRESH, pick_thr());
            add_reg(CFG_MAN_THRESH, pick_thr());
            len  = $urandom_range(10, 60);
            calm = ($urandom_range(0, 3) == 0);
            near = 1'($urandom_range(0, 1));
            for (k = 0; k < len; k++) begin
                gap  = calm ? 0 : pick_gap();
                base = $urandom_range(0, 1023);
                if (near)
                    add_item(near_reading(base), near_reading(base), near_reading(base),
                             near_reading(base), pick_reading(), $urandom_range(0, 1), gap);
                else
                    add_item(pick_reading(), pick_reading(), pick_reading(), pick_reading(),
                             pick_reading(), $urandom_range(0, 1), gap);
                n_sent++;
                if ($urandom_range(0, 99) == 0) add_wait();
            end
        end

        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (pending_jobs.size() != 0 || have_job || i_s_tvalid ||
               expected_angles.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (err_cnt == 0 && expected_angles.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #5000000;
        $display("tb: failure");
        $finish;
    end

endmodule
